// ===== rtl/dqs_pkg.sv =====
// dqs_pkg: shared types and constants for the deque_with_search block.
// Used by dqs_ctrl, dqs_datapath, deque_with_search and dqs_checker.
// No dependencies.
package dqs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 7;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   localparam logic [POS_W-1:0] POS_NONE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_READ_ALL   = 3'd4,
      ACT_SEARCH     = 3'd5,
      ACT_CLEAR      = 3'd6
   } dqs_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_MISS  = 2'd3
   } dqs_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT,
      S_POP,
      S_WALK,
      S_CMP
   } dqs_state_type;

   typedef enum logic [1:0] {
      RD_FRONT,
      RD_BACK,
      RD_NEXT
   } dqs_rdsel_type;

   typedef enum logic [2:0] {
      OUT_OK,
      OUT_EMPTY,
      OUT_FULL,
      OUT_DATA,
      OUT_FOUND,
      OUT_MISS
   } dqs_outkind_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_PUSH_FRONT,
      UPD_PUSH_BACK,
      UPD_POP_FRONT,
      UPD_POP_BACK,
      UPD_CLEAR
   } dqs_upd_type;

   typedef struct packed {
      logic            capture;
      logic            scan_start;
      logic            scan_step;
      logic            mem_rd;
      dqs_rdsel_type   rd_sel;
      logic            out_load;
      dqs_outkind_type out_kind;
      logic            out_last;
      dqs_upd_type     upd;
   } dqs_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                empty;
      logic                full;
      logic                out_free;
      logic                match;
      logic                scan_last;
   } dqs_stat_type;

endpackage

// ===== rtl/deque_with_search.sv =====
// deque_with_search: bounded double-ended queue of signed 32-bit items with search.
// Top level; instantiates dqs_ctrl and dqs_datapath. Depends on dqs_pkg.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser[2:0] action, tdata[31:0] value
//   rsp     | out | rsp_tvalid/tready    | tuser status, tdata data/position/empty/count,
//           |     |                      | tlast last
//
// Push, clear: result is loaded in EXEC. Pop: EXEC, WAIT, then POP (one registered RAM read).
// Read all: one item per cycle while rsp is not stalled; search: walks from the front to a match or the back.
// The ring RAM has a single read port and is walked one entry per cycle.
// Synchronous reset empties the queue; RAM contents are not cleared.
// A stalled rsp freezes the walk; one finished result may wait while a new request is taken.
module deque_with_search #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dqs_pkg::REQ_DATA_W-1:0]    req_tdata,   // [31:0] value
   input  logic [dqs_pkg::ACTION_W-1:0]      req_tuser,   // [2:0] action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dqs_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [31:0] data, [38:32] position,
                                                          // [39] empty, [46:40] count, [47] 0
   output logic [dqs_pkg::STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   output logic                              rsp_tlast
);

   dqs_pkg::dqs_cmd_type         cmd;
   dqs_pkg::dqs_stat_type        stat;
   dqs_pkg::dqs_status_type      status;
   logic [dqs_pkg::VALUE_W-1:0]  data;
   logic [dqs_pkg::POS_W-1:0]    position;
   logic                         empty_flag;
   logic [dqs_pkg::COUNT_W-1:0]  count;

   dqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dqs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_tuser),
      .req_value    (req_tdata[dqs_pkg::VALUE_W-1:0]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_status   (status),
      .rsp_data     (data),
      .rsp_position (position),
      .rsp_empty    (empty_flag),
      .rsp_count    (count),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, count, empty_flag, position, data};
   assign rsp_tuser = status;

endmodule

// ===== rtl/dqs_ctrl.sv =====
// dqs_ctrl: operation sequencer for deque_with_search.
// Drives dqs_datapath through dqs_pkg::dqs_cmd_type, reads dqs_pkg::dqs_stat_type.
// Depends on dqs_pkg.
module dqs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dqs_pkg::dqs_stat_type stat,
   output dqs_pkg::dqs_cmd_type  cmd
);

   dqs_pkg::dqs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dqs_pkg::S_IDLE: begin
            if (req_tvalid) state_in = dqs_pkg::S_EXEC;
         end
         dqs_pkg::S_EXEC: begin
            case (stat.action)
               dqs_pkg::ACT_PUSH_FRONT, dqs_pkg::ACT_PUSH_BACK, dqs_pkg::ACT_CLEAR: begin
                  if (stat.out_free) state_in = dqs_pkg::S_IDLE;
               end
               dqs_pkg::ACT_POP_FRONT, dqs_pkg::ACT_POP_BACK, dqs_pkg::ACT_READ_ALL,
               dqs_pkg::ACT_SEARCH: begin
                  if (!stat.empty) state_in = dqs_pkg::S_WAIT;
                  else if (stat.out_free) state_in = dqs_pkg::S_IDLE;
               end
               default: state_in = dqs_pkg::S_IDLE;
            endcase
         end
         dqs_pkg::S_WAIT: begin
            case (stat.action)
               dqs_pkg::ACT_READ_ALL: state_in = dqs_pkg::S_WALK;
               dqs_pkg::ACT_SEARCH:   state_in = dqs_pkg::S_CMP;
               default:               state_in = dqs_pkg::S_POP;
            endcase
         end
         dqs_pkg::S_POP: begin
            if (stat.out_free) state_in = dqs_pkg::S_IDLE;
         end
         dqs_pkg::S_WALK: begin
            if (stat.out_free && stat.scan_last) state_in = dqs_pkg::S_IDLE;
         end
         dqs_pkg::S_CMP: begin
            if ((stat.match || stat.scan_last) && stat.out_free) state_in = dqs_pkg::S_IDLE;
         end
         default: state_in = dqs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         dqs_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         dqs_pkg::S_EXEC: begin
            cmd.out_last = 1'b1;
            case (stat.action)
               dqs_pkg::ACT_PUSH_FRONT, dqs_pkg::ACT_PUSH_BACK: begin
                  cmd.out_load = stat.out_free;
                  if (stat.full) begin
                     cmd.out_kind = dqs_pkg::OUT_FULL;
                  end else begin
                     cmd.out_kind = dqs_pkg::OUT_OK;
                     if (stat.out_free) begin
                        cmd.upd = (stat.action == dqs_pkg::ACT_PUSH_FRONT) ?
                                  dqs_pkg::UPD_PUSH_FRONT : dqs_pkg::UPD_PUSH_BACK;
                     end
                  end
               end
               dqs_pkg::ACT_CLEAR: begin
                  cmd.out_load = stat.out_free;
                  cmd.out_kind = dqs_pkg::OUT_OK;
                  if (stat.out_free) cmd.upd = dqs_pkg::UPD_CLEAR;
               end
               dqs_pkg::ACT_POP_FRONT, dqs_pkg::ACT_POP_BACK, dqs_pkg::ACT_READ_ALL: begin
                  if (stat.empty) begin
                     cmd.out_load = stat.out_free;
                     cmd.out_kind = dqs_pkg::OUT_EMPTY;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.rd_sel     = (stat.action == dqs_pkg::ACT_POP_BACK) ?
                                      dqs_pkg::RD_BACK : dqs_pkg::RD_FRONT;
                  end
               end
               dqs_pkg::ACT_SEARCH: begin
                  if (stat.empty) begin
                     cmd.out_load = stat.out_free;
                     cmd.out_kind = dqs_pkg::OUT_MISS;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.rd_sel     = dqs_pkg::RD_FRONT;
                  end
               end
               default: ;
            endcase
         end
         dqs_pkg::S_POP: begin
            cmd.out_load = stat.out_free;
            cmd.out_kind = dqs_pkg::OUT_DATA;
            cmd.out_last = 1'b1;
            if (stat.out_free) begin
               cmd.upd = (stat.action == dqs_pkg::ACT_POP_BACK) ?
                         dqs_pkg::UPD_POP_BACK : dqs_pkg::UPD_POP_FRONT;
            end
         end
         dqs_pkg::S_WALK: begin
            cmd.out_load = stat.out_free;
            cmd.out_kind = dqs_pkg::OUT_DATA;
            cmd.out_last = stat.scan_last;
            if (stat.out_free && !stat.scan_last) begin
               cmd.scan_step = 1'b1;
               cmd.mem_rd    = 1'b1;
               cmd.rd_sel    = dqs_pkg::RD_NEXT;
            end
         end
         dqs_pkg::S_CMP: begin
            cmd.out_last = 1'b1;
            if (stat.match) begin
               cmd.out_load = stat.out_free;
               cmd.out_kind = dqs_pkg::OUT_FOUND;
            end else if (stat.scan_last) begin
               cmd.out_load = stat.out_free;
               cmd.out_kind = dqs_pkg::OUT_MISS;
            end else begin
               cmd.scan_step = 1'b1;
               cmd.mem_rd    = 1'b1;
               cmd.rd_sel    = dqs_pkg::RD_NEXT;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/dqs_datapath.sv =====
// dqs_datapath: ring storage, pointers, scan walker and result register.
// Controlled by dqs_ctrl through dqs_pkg::dqs_cmd_type.
// Depends on dqs_pkg.
module dqs_datapath #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dqs_pkg::ACTION_W-1:0]       req_action,
   input  logic [dqs_pkg::VALUE_W-1:0]        req_value,
   input  dqs_pkg::dqs_cmd_type               cmd,
   output dqs_pkg::dqs_stat_type              stat,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output dqs_pkg::dqs_status_type            rsp_status,
   output logic [dqs_pkg::VALUE_W-1:0]        rsp_data,
   output logic [dqs_pkg::POS_W-1:0]          rsp_position,
   output logic                               rsp_empty,
   output logic [dqs_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_last
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] TOP_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [dqs_pkg::VALUE_W-1:0] mem [DEPTH];

   logic [dqs_pkg::ACTION_W-1:0] action_ff;
   logic [dqs_pkg::VALUE_W-1:0]  value_ff;
   logic [PW-1:0]                front_ff, front_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [PW-1:0]                scan_ptr_ff, scan_idx_ff;
   logic [dqs_pkg::VALUE_W-1:0]  rdata_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   dqs_pkg::dqs_status_type      rsp_status_ff;
   logic [dqs_pkg::VALUE_W-1:0]  rsp_data_ff;
   logic [dqs_pkg::POS_W-1:0]    rsp_pos_ff;
   logic                         rsp_empty_ff;
   logic [dqs_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                         rsp_last_ff;

   logic [PW:0]   front_x, count_x;
   logic [PW-1:0] tail_slot, back_slot, dec_front, inc_front, next_ptr, rd_addr, wr_addr;
   logic          wr_en;

   function automatic logic [PW-1:0] wrap_sum(input logic [PW:0] s);
      logic [PW:0] d;
      d = s - DEPTH_X;
      if (s >= DEPTH_X) return d[PW-1:0];
      return s[PW-1:0];
   endfunction

   assign front_x   = {1'b0, front_ff};
   assign count_x   = (PW + 1)'(count_ff);
   assign tail_slot = wrap_sum(front_x + count_x);
   assign back_slot = wrap_sum(front_x + count_x - 1'b1);
   assign dec_front = (front_ff == '0) ? TOP_SLOT : front_ff - 1'b1;
   assign inc_front = (front_ff == TOP_SLOT) ? '0 : front_ff + 1'b1;
   assign next_ptr  = (scan_ptr_ff == TOP_SLOT) ? '0 : scan_ptr_ff + 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         dqs_pkg::RD_BACK: rd_addr = back_slot;
         dqs_pkg::RD_NEXT: rd_addr = next_ptr;
         default:          rd_addr = front_ff;
      endcase
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_slot;
      case (cmd.upd)
         dqs_pkg::UPD_PUSH_FRONT: begin
            front_in = dec_front;
            count_in = count_ff + 1'b1;
            wr_en    = 1'b1;
            wr_addr  = dec_front;
         end
         dqs_pkg::UPD_PUSH_BACK: begin
            count_in = count_ff + 1'b1;
            wr_en    = 1'b1;
         end
         dqs_pkg::UPD_POP_FRONT: begin
            front_in = inc_front;
            count_in = count_ff - 1'b1;
         end
         dqs_pkg::UPD_POP_BACK: begin
            count_in = count_ff - 1'b1;
         end
         dqs_pkg::UPD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= value_ff;
      if (cmd.mem_rd) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
      if (cmd.scan_start) begin
         scan_ptr_ff <= front_ff;
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ptr_ff <= next_ptr;
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_count_ff <= dqs_pkg::COUNT_W'(count_in);
         rsp_empty_ff <= (count_in == '0);
         rsp_last_ff  <= cmd.out_last;
         rsp_data_ff  <= '0;
         rsp_pos_ff   <= '0;
         case (cmd.out_kind)
            dqs_pkg::OUT_EMPTY: rsp_status_ff <= dqs_pkg::STAT_EMPTY;
            dqs_pkg::OUT_FULL:  rsp_status_ff <= dqs_pkg::STAT_FULL;
            dqs_pkg::OUT_DATA: begin
               rsp_status_ff <= dqs_pkg::STAT_OK;
               rsp_data_ff   <= rdata_ff;
            end
            dqs_pkg::OUT_FOUND: begin
               rsp_status_ff <= dqs_pkg::STAT_OK;
               rsp_pos_ff    <= dqs_pkg::POS_W'(scan_idx_ff);
            end
            dqs_pkg::OUT_MISS: begin
               rsp_status_ff <= dqs_pkg::STAT_MISS;
               rsp_pos_ff    <= dqs_pkg::POS_NONE;
            end
            default: rsp_status_ff <= dqs_pkg::STAT_OK;
         endcase
      end
   end

   always_comb begin
      stat.action    = action_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == FULL_CNT);
      stat.out_free  = ~rsp_valid_ff | rsp_tready;
      stat.match     = (rdata_ff == value_ff);
      stat.scan_last = ((CW'(scan_idx_ff) + CW'(1)) == count_ff);
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_empty    = rsp_empty_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== rtl/dqs_checker.sv =====
// dqs_checker: port-level assertions for deque_with_search, bound to the top level.
// Depends on dqs_pkg.
module dqs_checker #(
   parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dqs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [dqs_pkg::STATUS_W-1:0]      rsp_tuser,
   input logic                              rsp_tlast
);

   logic [dqs_pkg::COUNT_W-1:0] cnt;
   logic                        emp;

   assign cnt = rsp_tdata[46:40];
   assign emp = rsp_tdata[39];

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt <= dqs_pkg::COUNT_W'(DEPTH)) && (emp == (cnt == '0)))
      else $error("count out of range or empty flag mismatch");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dqs_pkg::STAT_FULL) |-> cnt == dqs_pkg::COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind deque_with_search dqs_checker #(.DEPTH(DEPTH)) u_dqs_checker (.*);
